@@ hw/rtl/sipf_pkg.sv @@
// ----------------------------------------------------------------------------
// sipf_pkg
// shared types and constants of the servo instruction packet framer
// ----------------------------------------------------------------------------
`default_nettype none

package sipf_pkg;

    // packet format
    localparam int unsigned MAX_PARAMS   = 16;
    localparam logic [4:0]  MAX_COUNT    = 5'(MAX_PARAMS);
    localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
    localparam logic [7:0]  WRITE_INST   = 8'd3;
    localparam logic [7:0]  LEN_OVERHEAD = 8'd2;
    localparam logic [4:0]  PKT_OVERHEAD = 5'd6;
    localparam logic [7:0]  REJECT_BYTE  = 8'h00;

    // configuration
    localparam logic [7:0]  LIMIT_RESET    = 8'd6;
    localparam logic        REG_PROT_LIMIT = 1'b0;

    // command queue
    localparam int unsigned QUEUE_DEPTH = 4;

    // byte positions inside one framed packet
    typedef logic [2:0] t_step;
    localparam t_step STEP_SYNC0 = 3'd0;
    localparam t_step STEP_SYNC1 = 3'd1;
    localparam t_step STEP_ID    = 3'd2;
    localparam t_step STEP_LEN   = 3'd3;
    localparam t_step STEP_INST  = 3'd4;
    localparam t_step STEP_PARAM = 3'd5;
    localparam t_step STEP_TAIL  = 3'd6;

    typedef enum logic [1:0] {
        CMD_HEADER,
        CMD_PARAM,
        CMD_REJECT
    } t_cmd_kind;

    // one classified item, ready for the byte sequencer
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] inst;
        logic [7:0] pb;
        logic       with_param;
        logic       with_sum;
        logic [7:0] sum;
        logic [4:0] pkt_len;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

`default_nettype wire

@@ hw/rtl/sipf_front.sv @@
// ----------------------------------------------------------------------------
// sipf_front
// accepts items, tracks packet state and classifies each item not being dropped into a command
// ----------------------------------------------------------------------------
`default_nettype none

module sipf_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_target_id,
    input  wire logic [7:0]        i_instruction,
    input  wire logic [4:0]        i_param_count,
    input  wire logic [7:0]        i_param_byte,
    input  wire logic [7:0]        i_limit,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output sipf_pkg::t_cmd         o_cmd
);

    logic       r_in_packet, n_in_packet;
    logic       r_dropping,  n_dropping;
    logic [4:0] r_params_left, n_params_left;
    logic [7:0] r_sum, n_sum;
    logic [4:0] r_latched, n_latched;

    logic       accept;
    logic [4:0] cnt;
    logic [4:0] cnt_m1;
    logic [7:0] len;
    logic [7:0] sum_hdr;
    logic [7:0] sum_first;
    logic [7:0] sum_next;
    logic [4:0] left_m1;
    logic       reject;

    // while dropping nothing is queued, so the queue cannot stall us
    assign o_ready = r_dropping | ~i_q_full;
    assign accept  = i_valid & o_ready;

    assign cnt       = (i_param_count > sipf_pkg::MAX_COUNT) ? sipf_pkg::MAX_COUNT
                                                             : i_param_count;
    assign cnt_m1    = cnt - 5'd1;
    assign len       = {3'b000, cnt} + sipf_pkg::LEN_OVERHEAD;
    assign sum_hdr   = i_target_id + len + i_instruction;
    assign sum_first = sum_hdr + i_param_byte;
    assign sum_next  = r_sum + i_param_byte;
    assign left_m1   = r_params_left - 5'd1;
    assign reject    = (cnt != 5'd0) && (i_instruction == sipf_pkg::WRITE_INST)
                       && (i_param_byte < i_limit);

    always_comb begin
        n_in_packet   = r_in_packet;
        n_dropping    = r_dropping;
        n_params_left = r_params_left;
        n_sum         = r_sum;
        n_latched     = r_latched;
        o_push        = 1'b0;

        o_cmd            = '0;
        o_cmd.kind       = sipf_pkg::CMD_PARAM;
        o_cmd.id         = i_target_id;
        o_cmd.len        = len;
        o_cmd.inst       = i_instruction;
        o_cmd.pb         = i_param_byte;
        o_cmd.with_param = 1'b1;

        if (accept) begin
            if (!r_in_packet) begin
                n_latched = cnt;
                o_push    = 1'b1;
                if (reject) begin
                    o_cmd.kind    = sipf_pkg::CMD_REJECT;
                    n_params_left = cnt_m1;
                    n_in_packet   = (cnt_m1 != 5'd0);
                    n_dropping    = (cnt_m1 != 5'd0);
                end else begin
                    o_cmd.kind    = sipf_pkg::CMD_HEADER;
                    o_cmd.pkt_len = cnt + sipf_pkg::PKT_OVERHEAD;
                    n_dropping    = 1'b0;
                    if (cnt == 5'd0) begin
                        o_cmd.with_param = 1'b0;
                        o_cmd.with_sum   = 1'b1;
                        o_cmd.sum        = ~sum_hdr;
                        n_sum            = sum_hdr;
                        n_in_packet      = 1'b0;
                        n_params_left    = 5'd0;
                    end else begin
                        n_sum         = sum_first;
                        n_params_left = cnt_m1;
                        o_cmd.sum     = ~sum_first;
                        if (cnt_m1 == 5'd0) begin
                            o_cmd.with_sum = 1'b1;
                            n_in_packet    = 1'b0;
                        end else begin
                            n_in_packet = 1'b1;
                        end
                    end
                end
            end else if (r_dropping) begin
                if (r_params_left != 5'd0) begin
                    n_params_left = left_m1;
                end
                if (r_params_left <= 5'd1) begin
                    n_in_packet = 1'b0;
                    n_dropping  = 1'b0;
                end
            end else begin
                o_push        = 1'b1;
                o_cmd.kind    = sipf_pkg::CMD_PARAM;
                o_cmd.sum     = ~sum_next;
                o_cmd.pkt_len = r_latched + sipf_pkg::PKT_OVERHEAD;
                n_sum         = sum_next;
                if (r_params_left != 5'd0) begin
                    n_params_left = left_m1;
                end
                if (r_params_left <= 5'd1) begin
                    o_cmd.with_sum = 1'b1;
                    n_in_packet    = 1'b0;
                    n_dropping     = 1'b0;
                    n_params_left  = 5'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet   <= 1'b0;
            r_dropping    <= 1'b0;
            r_params_left <= 5'd0;
            r_sum         <= 8'd0;
            r_latched     <= 5'd0;
        end else begin
            r_in_packet   <= n_in_packet;
            r_dropping    <= n_dropping;
            r_params_left <= n_params_left;
            r_sum         <= n_sum;
            r_latched     <= n_latched;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sipf_queue.sv @@
// ----------------------------------------------------------------------------
// sipf_queue
// small command fifo between the front and the byte sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module sipf_queue #(
    parameter int unsigned DEPTH = sipf_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sipf_pkg::t_cmd   i_cmd,
    output logic                  o_full,
    input  wire logic             i_pop,
    output sipf_pkg::t_q_head     o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sipf_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd];

    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_head.valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sipf_back.sv @@
// ----------------------------------------------------------------------------
// sipf_back
// byte sequencer: while i_ready allows, expands each command into framed bytes, one per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sipf_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sipf_pkg::t_q_head i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_tx_byte,
    output logic                   o_last,
    output logic                   o_rejected,
    output logic [4:0]             o_packet_length
);

    logic             r_busy, n_busy;
    sipf_pkg::t_step  r_step, n_step;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             r_rej;
    logic [4:0]       r_len;

    logic             load;
    sipf_pkg::t_step  cur_step;
    sipf_pkg::t_step  end_step;
    logic             is_sum;
    logic             done;
    logic [7:0]       nx_byte;
    logic             nx_last;
    logic             nx_rej;
    logic [4:0]       nx_len;

    sipf_pkg::t_cmd cmd;
    assign cmd = i_head.cmd;

    // output stage takes a new byte when empty or being drained
    assign load = ~r_out_valid | i_ready;

    assign cur_step = r_busy ? r_step
                    : ((cmd.kind == sipf_pkg::CMD_PARAM) ? sipf_pkg::STEP_PARAM
                                                         : sipf_pkg::STEP_SYNC0);
    assign end_step = (cmd.with_sum && cmd.with_param) ? sipf_pkg::STEP_TAIL
                                                       : sipf_pkg::STEP_PARAM;
    assign is_sum = cmd.with_sum &&
                    ((cur_step == sipf_pkg::STEP_TAIL) ||
                     ((cur_step == sipf_pkg::STEP_PARAM) && !cmd.with_param));

    always_comb begin
        nx_byte = sipf_pkg::SYNC_BYTE;
        nx_last = is_sum;
        nx_rej  = 1'b0;
        nx_len  = is_sum ? cmd.pkt_len : 5'd0;
        done    = (cur_step == end_step);
        case (cmd.kind)
            sipf_pkg::CMD_REJECT: begin
                nx_byte = sipf_pkg::REJECT_BYTE;
                nx_last = 1'b1;
                nx_rej  = 1'b1;
                nx_len  = 5'd0;
                done    = 1'b1;
            end
            default: begin
                case (cur_step)
                    sipf_pkg::STEP_SYNC0: nx_byte = sipf_pkg::SYNC_BYTE;
                    sipf_pkg::STEP_SYNC1: nx_byte = sipf_pkg::SYNC_BYTE;
                    sipf_pkg::STEP_ID:    nx_byte = cmd.id;
                    sipf_pkg::STEP_LEN:   nx_byte = cmd.len;
                    sipf_pkg::STEP_INST:  nx_byte = cmd.inst;
                    sipf_pkg::STEP_PARAM: nx_byte = cmd.with_param ? cmd.pb : cmd.sum;
                    default:              nx_byte = cmd.sum;
                endcase
            end
        endcase
    end

    assign o_pop = load & i_head.valid & done;

    always_comb begin
        n_busy      = r_busy;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = i_head.valid;
            if (i_head.valid) begin
                n_busy = ~done;
                n_step = cur_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= sipf_pkg::STEP_SYNC0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head.valid) begin
            r_byte <= nx_byte;
            r_last <= nx_last;
            r_rej  <= nx_rej;
            r_len  <= nx_len;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_tx_byte       = r_byte;
    assign o_last          = r_last;
    assign o_rejected      = r_rej;
    assign o_packet_length = r_len;

endmodule

`default_nettype wire

@@ hw/rtl/servo_instruction_packet_framer.sv @@
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer
// frames servo instruction packets: FF FF id len inst params checksum
// ----------------------------------------------------------------------------
// Each input item carries one parameter byte; the first item of a packet also
// supplies the target id, instruction and parameter count (saturated at 16).
// The block sends FF FF id len inst params checksum on the output, with
// len = count+2 and checksum = ~(id+len+inst+params). A write (instruction 3)
// whose first parameter is below protected_address_limit is refused: a single
// marker byte (0, last and rejected set) goes out and the rest of that packet's
// items are swallowed. A count of zero makes the first item alone produce the
// whole six-byte packet. Input items are accepted one per cycle while the
// command queue has room; the output runs at one byte per cycle while i_ready
// allows. A first item yields the sync bytes, id, len, inst and its parameter,
// and every later item its parameter; the last item adds the checksum. An
// accepted item that is not swallowed is written into the queue, and its first byte is then
// loaded into the output register once the sequencer and the output can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_instruction_packet_framer #(
    parameter int unsigned QUEUE_DEPTH = sipf_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // item input
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_target_id,
    input  wire logic [7:0]  i_instruction,
    input  wire logic [4:0]  i_param_count,
    input  wire logic [7:0]  i_param_byte,

    // byte output
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_tx_byte,
    output logic             o_last,
    output logic             o_rejected,
    output logic [4:0]       o_packet_length,

    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // protected address limit register
    logic [7:0] r_limit, n_limit;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        n_limit = r_limit;
        if (cfg_wr && (paddr[2] == sipf_pkg::REG_PROT_LIMIT)) begin
            n_limit = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= sipf_pkg::LIMIT_RESET;
        end else begin
            r_limit <= n_limit;
        end
    end

    assign prdata = (paddr[2] == sipf_pkg::REG_PROT_LIMIT) ? {24'd0, r_limit} : 32'd0;

    // front: classify items into commands
    logic              q_full;
    logic              q_push;
    sipf_pkg::t_cmd    q_cmd;
    sipf_pkg::t_q_head q_head;
    logic              q_pop;

    sipf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_target_id   (i_target_id),
        .i_instruction (i_instruction),
        .i_param_count (i_param_count),
        .i_param_byte  (i_param_byte),
        .i_limit       (r_limit),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (q_cmd)
    );

    // queue: decouples item intake from byte output
    sipf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // back: expand commands into framed bytes
    sipf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_tx_byte       (o_tx_byte),
        .o_last          (o_last),
        .o_rejected      (o_rejected),
        .o_packet_length (o_packet_length)
    );

    // a command is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // the reject marker ends a packet and carries no length
    a_reject_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> (o_last && o_packet_length == 5'd0
                                     && o_tx_byte == sipf_pkg::REJECT_BYTE))
        else $error("malformed reject marker");

    // a checksum byte always reports at least the fixed overhead
    a_sum_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && !o_rejected) |-> (o_packet_length >= sipf_pkg::PKT_OVERHEAD))
        else $error("checksum byte with short packet length");

endmodule

`default_nettype wire
